/* sv/csi_escape_sequence_decoder_macros.svh */
// Assertion helpers for the decoder top level, which includes this file.
`ifndef CSI_ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define CSI_ESCAPE_SEQUENCE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSIED_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csied assertion failed");

// Next-cycle implication, checked outside reset.
`define CSIED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csied assertion failed");

`endif

/* sv/csied_pkg.sv */
`timescale 1ns / 1ps

package csied_pkg;

   // Byte codes of the control sequence syntax
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_B  = 8'h42;
   localparam logic [7:0] CH_UPPER_C  = 8'h43;
   localparam logic [7:0] CH_UPPER_D  = 8'h44;
   localparam logic [7:0] CH_UPPER_E  = 8'h45;
   localparam logic [7:0] CH_UPPER_F  = 8'h46;
   localparam logic [7:0] CH_UPPER_G  = 8'h47;
   localparam logic [7:0] CH_UPPER_H  = 8'h48;
   localparam logic [7:0] CH_UPPER_J  = 8'h4A;
   localparam logic [7:0] CH_UPPER_K  = 8'h4B;
   localparam logic [7:0] CH_UPPER_S  = 8'h53;
   localparam logic [7:0] CH_UPPER_T  = 8'h54;
   localparam logic [7:0] CH_LOWER_M  = 8'h6D;

   // Parameter field currently being filled
   localparam logic [1:0] SLOT_ROW  = 2'd0;
   localparam logic [1:0] SLOT_COL  = 2'd1;
   localparam logic [1:0] SLOT_DROP = 2'd2;

   // Width of a decimal digit value and of the result parameters
   localparam int DIGIT_BITS = 4;
   localparam int OUT_BITS   = 16;

   typedef enum logic [3:0] {
      CMD_UP          = 4'd0,
      CMD_DOWN        = 4'd1,
      CMD_FORWARD     = 4'd2,
      CMD_BACK        = 4'd3,
      CMD_NEXTLINE    = 4'd4,
      CMD_PREVLINE    = 4'd5,
      CMD_COLUMN      = 4'd6,
      CMD_POSITION    = 4'd7,
      CMD_ERASE       = 4'd8,
      CMD_ERASELINE   = 4'd9,
      CMD_SCROLLUP    = 4'd10,
      CMD_SCROLLDOWN  = 4'd11,
      CMD_GRAPHIC     = 4'd12
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_ESC  = 3'b010,
      PH_CSI  = 3'b100
   } phase_type;

   typedef struct packed {
      logic    hit;
      cmd_type cmd;
   } final_type;

   // Map a final letter to its command
   function automatic final_type final_lookup(input logic [7:0] b);
      final_type r;
      r.hit = 1'b1;
      r.cmd = CMD_UP;
      case (b)
         CH_UPPER_A: r.cmd = CMD_UP;
         CH_UPPER_B: r.cmd = CMD_DOWN;
         CH_UPPER_C: r.cmd = CMD_FORWARD;
         CH_UPPER_D: r.cmd = CMD_BACK;
         CH_UPPER_E: r.cmd = CMD_NEXTLINE;
         CH_UPPER_F: r.cmd = CMD_PREVLINE;
         CH_UPPER_G: r.cmd = CMD_COLUMN;
         CH_UPPER_H: r.cmd = CMD_POSITION;
         CH_UPPER_J: r.cmd = CMD_ERASE;
         CH_UPPER_K: r.cmd = CMD_ERASELINE;
         CH_UPPER_S: r.cmd = CMD_SCROLLUP;
         CH_UPPER_T: r.cmd = CMD_SCROLLDOWN;
         CH_LOWER_M: r.cmd = CMD_GRAPHIC;
         default: begin
            r.hit = 1'b0;
            r.cmd = CMD_UP;
         end
      endcase
      return r;
   endfunction

endpackage

/* sv/csied_digit_acc.sv */
`timescale 1ns / 1ps

module csied_digit_acc
   import csied_pkg::*;
#(
   parameter int PARAM_BITS = 16
) (
   input  logic [PARAM_BITS-1:0] acc,
   input  logic [DIGIT_BITS-1:0] digit,
   output logic [PARAM_BITS-1:0] acc_next
);

   localparam int WideBits = PARAM_BITS + 4;

   logic [WideBits-1:0] acc_wide;
   logic [WideBits-1:0] sum;

   // Multiply by ten as two shifts, then add the digit
   assign acc_wide = WideBits'(acc);
   assign sum      = (acc_wide << 3) + (acc_wide << 1) + WideBits'(digit);

   // Saturate at the top of the field
   assign acc_next = (sum[WideBits-1:PARAM_BITS] != '0) ? '1 : sum[PARAM_BITS-1:0];

endmodule

/* sv/csi_escape_sequence_decoder.sv */
`timescale 1ns / 1ps

// Control sequence decoder for a terminal byte stream.
// req_ channel: one byte of terminal output per item (req_in_byte), taken
// at a clock edge where req_valid is high and req_stall is low.
// rsp_ channel: one command item per complete ESC '[' ... final-letter
// sequence, with rsp_command, rsp_first_param and rsp_second_param.
// Bytes outside a sequence, digits, ';' and other bytes inside one give no item.
// A byte that ends a sequence passes through the input register and then
// the result register, from which its item is offered on rsp_.
// Throughput: one byte per cycle, but for the wait described next; the
// decode is a single registered step on the parser state (a multiply-by-ten
// adder and a few compares). When rsp_stall holds a waiting item, bytes that
// give no item keep flowing; only a byte that ends a sequence waits, and
// req_stall rises. Reset (synchronous, active high) empties both registers
// and returns the parser to idle with all parameter fields cleared.
module csi_escape_sequence_decoder
   import csied_pkg::*;
#(
   parameter int PARAM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_command,
   output logic [15:0] rsp_first_param,
   output logic [15:0] rsp_second_param
);

`include "csi_escape_sequence_decoder_macros.svh"

   localparam int ExtBits = (PARAM_BITS > OUT_BITS) ? PARAM_BITS : OUT_BITS;

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;

   // Parser state
   phase_type             phase_ff, phase_in;
   logic [1:0]            slot_ff, slot_in;
   logic [PARAM_BITS-1:0] row_ff, row_in;
   logic [PARAM_BITS-1:0] col_ff, col_in;
   logic                  row_seen_ff, row_seen_in;
   logic                  col_seen_ff, col_seen_in;
   logic                  any_seen_ff, any_seen_in;

   // Result register
   logic           rsp_valid_ff, rsp_valid_in;
   cmd_type        rsp_command_ff;
   logic [15:0]    rsp_first_ff, rsp_second_ff;

   logic                  req_accept;
   logic                  s1_emit;
   logic                  s1_fire;
   final_type             fin;
   logic                  is_digit;
   logic [DIGIT_BITS-1:0] digit;
   logic [PARAM_BITS-1:0] row_sum, col_sum;
   logic [PARAM_BITS-1:0] p1, p2;
   logic [ExtBits-1:0]    p1_ext, p2_ext;

   // Decode the held byte
   assign fin      = final_lookup(s1_byte_ff);
   assign is_digit = (s1_byte_ff >= CH_ZERO) && (s1_byte_ff <= CH_NINE);
   assign digit    = DIGIT_BITS'(s1_byte_ff - CH_ZERO);

   csied_digit_acc #(.PARAM_BITS(PARAM_BITS)) u_row_acc (
      .acc      (row_ff),
      .digit    (digit),
      .acc_next (row_sum)
   );

   csied_digit_acc #(.PARAM_BITS(PARAM_BITS)) u_col_acc (
      .acc      (col_ff),
      .digit    (digit),
      .acc_next (col_sum)
   );

   // Advance the held item unless it ends a sequence and the result is blocked
   assign s1_emit    = (phase_ff == PH_CSI) && fin.hit;
   assign s1_fire    = s1_valid_ff && (!s1_emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = req_accept | (s1_valid_ff & ~s1_fire);

   // Apply defaults to the parameters
   always_comb begin
      if (fin.cmd == CMD_POSITION) begin
         p1 = row_seen_ff ? row_ff : PARAM_BITS'(1);
         p2 = col_seen_ff ? col_ff : PARAM_BITS'(1);
      end else begin
         p1 = any_seen_ff ? row_ff : PARAM_BITS'(1);
         p2 = '0;
      end
   end

   assign p1_ext = ExtBits'(p1);
   assign p2_ext = ExtBits'(p2);

   // Step the parser state
   always_comb begin
      phase_in    = phase_ff;
      slot_in     = slot_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      row_seen_in = row_seen_ff;
      col_seen_in = col_seen_ff;
      any_seen_in = any_seen_ff;
      if (s1_fire) begin
         case (phase_ff)
            PH_IDLE: begin
               if (s1_byte_ff == CH_ESC) begin
                  phase_in = PH_ESC;
               end
            end
            PH_ESC: begin
               if (s1_byte_ff == CH_LBRACKET) begin
                  phase_in    = PH_CSI;
                  slot_in     = SLOT_ROW;
                  row_in      = '0;
                  col_in      = '0;
                  row_seen_in = 1'b0;
                  col_seen_in = 1'b0;
                  any_seen_in = 1'b0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CSI: begin
               if (fin.hit) begin
                  phase_in    = PH_IDLE;
                  slot_in     = SLOT_ROW;
                  row_in      = '0;
                  col_in      = '0;
                  row_seen_in = 1'b0;
                  col_seen_in = 1'b0;
                  any_seen_in = 1'b0;
               end else begin
                  any_seen_in = 1'b1;
                  if (is_digit) begin
                     if (slot_ff == SLOT_ROW) begin
                        row_in      = row_sum;
                        row_seen_in = 1'b1;
                     end else if (slot_ff == SLOT_COL) begin
                        col_in      = col_sum;
                        col_seen_in = 1'b1;
                     end
                  end else if ((s1_byte_ff == CH_SEMI) && (slot_ff != SLOT_DROP)) begin
                     slot_in = slot_ff + 2'd1;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Load or drain the result register
   always_comb begin
      if (s1_fire && s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         slot_ff      <= SLOT_ROW;
         row_ff       <= '0;
         col_ff       <= '0;
         row_seen_ff  <= 1'b0;
         col_seen_ff  <= 1'b0;
         any_seen_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         row_seen_ff  <= row_seen_in;
         col_seen_ff  <= col_seen_in;
         any_seen_ff  <= any_seen_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_in_byte;
      end
      if (s1_fire && s1_emit) begin
         rsp_command_ff <= fin.cmd;
         rsp_first_ff   <= p1_ext[OUT_BITS-1:0];
         rsp_second_ff  <= p2_ext[OUT_BITS-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command      = rsp_command_ff;
   assign rsp_first_param  = rsp_first_ff;
   assign rsp_second_param = rsp_second_ff;

   // Checks
   `CSIED_ASSERT_NOW(a_second_zero, clock, reset, rsp_valid && (rsp_command != CMD_POSITION), rsp_second_param == 16'd0)
   `CSIED_ASSERT_NOW(a_cmd_range, clock, reset, rsp_valid, rsp_command <= CMD_GRAPHIC)
   `CSIED_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CSIED_ASSERT_NOW(a_emit_only_csi, clock, reset, s1_fire && s1_emit, phase_ff == PH_CSI)

endmodule
